/* rtl/core/pbwd_pkg.sv */
// ----------------------------------------------------------------------------
// pbwd_pkg
// Shared constants and register indexes for the periodic box wrap and
// distance block.
// ----------------------------------------------------------------------------
package pbwd_pkg;

    localparam int DIMENSIONS_DEF  = 3;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int AXES            = 3;
    localparam int CFG_IDX_W       = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIODIC = 3'd0,
        CFG_LOWER_X  = 3'd1,
        CFG_LOWER_Y  = 3'd2,
        CFG_LOWER_Z  = 3'd3,
        CFG_UPPER_X  = 3'd4,
        CFG_UPPER_Y  = 3'd5,
        CFG_UPPER_Z  = 3'd6
    } t_cfg_index;

endpackage

/* rtl/core/periodic_box_wrap_and_distance.sv */
// ----------------------------------------------------------------------------
// periodic_box_wrap_and_distance
// Box test, box wrap, and distance of two points (minimum-image if periodic).
//
// Input channel (i_valid / o_ready) takes one word per cycle while o_ready is
// high: points a and b, signed fixed point. Output channel (o_valid / i_ready)
// returns a_inside, a wrapped into the box, and the distance from a to b
// rounded down. Configuration channel (i_cfg_valid / o_cfg_ready) writes the
// periodic flag and the box bounds; it is always ready. Write it only while no
// word is in flight.
// The distance path runs through the difference and square stages, a sum
// register and the pipelined square root, one root bit per stage. The wrap
// divider, one bit per stage, runs alongside.
// Throughput is one word per cycle while the receiver does not stall.
// Reset clears the pipeline valid bits and the config registers to zero.
// When the receiver stalls, the whole pipeline holds and o_ready drops; an
// empty output stage lets the pipeline advance.
// ----------------------------------------------------------------------------
module periodic_box_wrap_and_distance #(
    parameter int DIMENSIONS  = pbwd_pkg::DIMENSIONS_DEF,
    parameter int COORD_WIDTH = pbwd_pkg::COORD_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pbwd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [COORD_WIDTH-1:0]           i_cfg_data,

    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic signed [COORD_WIDTH-1:0]    i_point_a_x,
    input  logic signed [COORD_WIDTH-1:0]    i_point_a_y,
    input  logic signed [COORD_WIDTH-1:0]    i_point_a_z,
    input  logic signed [COORD_WIDTH-1:0]    i_point_b_x,
    input  logic signed [COORD_WIDTH-1:0]    i_point_b_y,
    input  logic signed [COORD_WIDTH-1:0]    i_point_b_z,

    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_a_inside,
    output logic signed [COORD_WIDTH-1:0]    o_wrapped_x,
    output logic signed [COORD_WIDTH-1:0]    o_wrapped_y,
    output logic signed [COORD_WIDTH-1:0]    o_wrapped_z,
    output logic [COORD_WIDTH:0]             o_distance
);
    localparam int W    = COORD_WIDTH;
    localparam int NA   = pbwd_pkg::AXES;
    localparam int RW   = W + 2;
    localparam int SQW  = 2 * RW;
    localparam int SW   = 2 * RW + 2;
    localparam int LAT  = W + 9;
    localparam int WDLY = LAT - (W + 4);

    logic                r_periodic;
    logic signed [W-1:0] r_lower [0:NA-1];
    logic signed [W-1:0] r_upper [0:NA-1];
    logic [LAT-1:0]      r_vld;
    logic                en;

    logic signed [W-1:0] w_a     [0:NA-1];
    logic signed [W-1:0] w_b     [0:NA-1];
    logic [SQW-1:0]      w_sq    [0:NA-1];
    logic signed [W-1:0] w_wrap  [0:NA-1];
    logic                w_ins   [0:NA-1];
    logic [SW-1:0]       r_sum;
    logic [RW-1:0]       w_root;

    assign w_a[0] = i_point_a_x;
    assign w_a[1] = i_point_a_y;
    assign w_a[2] = i_point_a_z;
    assign w_b[0] = i_point_b_x;
    assign w_b[1] = i_point_b_y;
    assign w_b[2] = i_point_b_z;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_periodic <= 1'b0;
            for (int j = 0; j < NA; j++) begin
                r_lower[j] <= '0;
                r_upper[j] <= '0;
            end
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pbwd_pkg::CFG_PERIODIC: r_periodic <= i_cfg_data[0];
                pbwd_pkg::CFG_LOWER_X:  r_lower[0] <= i_cfg_data;
                pbwd_pkg::CFG_LOWER_Y:  r_lower[1] <= i_cfg_data;
                pbwd_pkg::CFG_LOWER_Z:  r_lower[2] <= i_cfg_data;
                pbwd_pkg::CFG_UPPER_X:  r_upper[0] <= i_cfg_data;
                pbwd_pkg::CFG_UPPER_Y:  r_upper[1] <= i_cfg_data;
                pbwd_pkg::CFG_UPPER_Z:  r_upper[2] <= i_cfg_data;
                default: ;  // drop writes to unknown indexes
            endcase
        end
    end

    // advance everything unless a finished word waits at the output
    assign en      = !r_vld[LAT-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    for (genvar j = 0; j < NA; j++) begin : g_axis
        if (j < DIMENSIONS) begin : g_on
            logic signed [W-1:0] n_wrap;
            logic                n_ins;
            logic [W:0]          r_dly [0:WDLY-1];

            pbwd_wrap #(.COORD_WIDTH(W)) u_wrap (
                .i_clk     (i_clk),
                .i_en      (en),
                .i_a       (w_a[j]),
                .i_lo      (r_lower[j]),
                .i_hi      (r_upper[j]),
                .o_inside  (n_ins),
                .o_wrapped (n_wrap)
            );

            pbwd_diff #(.COORD_WIDTH(W)) u_diff (
                .i_clk      (i_clk),
                .i_en       (en),
                .i_periodic (r_periodic),
                .i_a        (w_a[j]),
                .i_b        (w_b[j]),
                .i_lo       (r_lower[j]),
                .i_hi       (r_upper[j]),
                .o_sq       (w_sq[j])
            );

            // align the wrap path with the longer distance path
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dly[0] <= {n_ins, n_wrap};
                    for (int k = 1; k < WDLY; k++) begin
                        r_dly[k] <= r_dly[k-1];
                    end
                end
            end

            assign w_ins[j]  = r_dly[WDLY-1][W];
            assign w_wrap[j] = r_dly[WDLY-1][W-1:0];
        end else begin : g_off
            assign w_ins[j]  = 1'b1;
            assign w_wrap[j] = '0;
            assign w_sq[j]   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sum <= SW'(w_sq[0]) + SW'(w_sq[1]) + SW'(w_sq[2]);
        end
    end

    pbwd_isqrt #(.ROOT_WIDTH(RW)) u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_sum  (r_sum),
        .o_root (w_root)
    );

    assign o_a_inside  = w_ins[0] && w_ins[1] && w_ins[2];
    assign o_wrapped_x = w_wrap[0];
    assign o_wrapped_y = w_wrap[1];
    assign o_wrapped_z = w_wrap[2];
    // saturate a root that does not fit the output width
    assign o_distance  = w_root[RW-1] ? '1 : w_root[W:0];

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> (r_vld == $past(r_vld)))
        else $error("pipeline valid bits moved during a stall");

    a_entry_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en |=> (r_vld[0] == $past(i_valid)))
        else $error("first stage valid does not follow the accepted word");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && !i_valid && !r_vld[LAT-1]) |=>
            ($countones(r_vld) == $past($countones(r_vld))))
        else $error("word count in the pipeline changed without transfer");

endmodule

/* rtl/core/pbwd_wrap.sv */
// ----------------------------------------------------------------------------
// pbwd_wrap
// One axis: inside test on [lower, upper] and, for a coordinate outside it,
// wrap into [lower, upper) by floor-modulo with a restoring divider, one
// quotient bit per stage, when upper is above lower.
// ----------------------------------------------------------------------------
module pbwd_wrap #(
    parameter int COORD_WIDTH = pbwd_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [COORD_WIDTH-1:0] i_a,
    input  logic signed [COORD_WIDTH-1:0] i_lo,
    input  logic signed [COORD_WIDTH-1:0] i_hi,
    output logic                          o_inside,
    output logic signed [COORD_WIDTH-1:0] o_wrapped
);
    localparam int W  = COORD_WIDTH;
    localparam int NQ = W + 1;

    logic signed [W:0] n_off;
    logic signed [W:0] n_size;
    logic              n_inside;

    logic [W-1:0] w_a    [0:NQ];
    logic [W-1:0] w_lo   [0:NQ];
    logic [W-1:0] w_size [0:NQ];
    logic [W-1:0] w_rem  [0:NQ];
    logic [W:0]   w_dvd  [0:NQ];
    logic         w_neg  [0:NQ];
    logic         w_ins  [0:NQ];
    logic         w_wrp  [0:NQ];

    logic [W-1:0] r0_a, r0_lo, r0_size;
    logic [W:0]   r0_dvd;
    logic         r0_neg, r0_ins, r0_wrp;

    assign n_off    = {i_a[W-1], i_a} - {i_lo[W-1], i_lo};
    assign n_size   = {i_hi[W-1], i_hi} - {i_lo[W-1], i_lo};
    assign n_inside = (i_a >= i_lo) && (i_a <= i_hi);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_a    <= i_a;
            r0_lo   <= i_lo;
            r0_size <= n_size[W-1:0];
            r0_dvd  <= n_off[W] ? -n_off : n_off;
            r0_neg  <= n_off[W];
            r0_ins  <= n_inside;
            r0_wrp  <= !n_size[W] && (n_size != '0) && !n_inside;
        end
    end

    assign w_a[0]    = r0_a;
    assign w_lo[0]   = r0_lo;
    assign w_size[0] = r0_size;
    assign w_rem[0]  = '0;
    assign w_dvd[0]  = r0_dvd;
    assign w_neg[0]  = r0_neg;
    assign w_ins[0]  = r0_ins;
    assign w_wrp[0]  = r0_wrp;

    for (genvar k = 0; k < NQ; k++) begin : g_div
        logic [W:0]   n_t;
        logic [W:0]   n_d;
        logic         n_ge;
        logic [W-1:0] r_a, r_lo, r_size, r_rem;
        logic [W:0]   r_dvd;
        logic         r_neg, r_ins, r_wrp;

        assign n_t  = {w_rem[k], w_dvd[k][W]};
        assign n_d  = n_t - {1'b0, w_size[k]};
        assign n_ge = n_t >= {1'b0, w_size[k]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= n_ge ? n_d[W-1:0] : n_t[W-1:0];
                r_dvd  <= {w_dvd[k][W-1:0], 1'b0};
                r_a    <= w_a[k];
                r_lo   <= w_lo[k];
                r_size <= w_size[k];
                r_neg  <= w_neg[k];
                r_ins  <= w_ins[k];
                r_wrp  <= w_wrp[k];
            end
        end

        assign w_a[k+1]    = r_a;
        assign w_lo[k+1]   = r_lo;
        assign w_size[k+1] = r_size;
        assign w_rem[k+1]  = r_rem;
        assign w_dvd[k+1]  = r_dvd;
        assign w_neg[k+1]  = r_neg;
        assign w_ins[k+1]  = r_ins;
        assign w_wrp[k+1]  = r_wrp;
    end

    logic [W-1:0] r1_r, r1_a, r1_lo;
    logic         r1_ins, r1_wrp;
    logic [W-1:0] r2_w;
    logic         r2_ins;

    // fold a truncated remainder of a negative offset up to the floor remainder
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_r   <= (w_neg[NQ] && (w_rem[NQ] != '0)) ? w_size[NQ] - w_rem[NQ] : w_rem[NQ];
            r1_a   <= w_a[NQ];
            r1_lo  <= w_lo[NQ];
            r1_ins <= w_ins[NQ];
            r1_wrp <= w_wrp[NQ];
            r2_w   <= r1_wrp ? r1_lo + r1_r : r1_a;
            r2_ins <= r1_ins;
        end
    end

    assign o_inside  = r2_ins;
    assign o_wrapped = r2_w;

endmodule

/* rtl/core/pbwd_diff.sv */
// ----------------------------------------------------------------------------
// pbwd_diff
// One axis: difference a - b, minimum-image correction, magnitude and square.
// ----------------------------------------------------------------------------
module pbwd_diff #(
    parameter int COORD_WIDTH = pbwd_pkg::COORD_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic                           i_periodic,
    input  logic signed [COORD_WIDTH-1:0]  i_a,
    input  logic signed [COORD_WIDTH-1:0]  i_b,
    input  logic signed [COORD_WIDTH-1:0]  i_lo,
    input  logic signed [COORD_WIDTH-1:0]  i_hi,
    output logic [2*(COORD_WIDTH+2)-1:0]   o_sq
);
    localparam int W  = COORD_WIDTH;
    localparam int MW = W + 2;
    localparam int LW = MW / 2;
    localparam int HW = MW - LW;
    localparam int SW = 2 * MW;

    logic signed [W:0]    n1_size;
    logic signed [W:0]    r1_d, r1_size;
    logic                 r1_c;

    logic signed [W+1:0]  n2_d2, n2_sz, n2_dx;
    logic signed [W+1:0]  r2_d, r2_size;
    logic                 r2_c;

    logic signed [W+2:0]  n3_d2, n3_nsz;
    logic signed [W+1:0]  r3_d;
    logic [MW-1:0]        r4_m;

    logic [2*HW-1:0]      r5_hh;
    logic [HW+LW-1:0]     r5_hl;
    logic [2*LW-1:0]      r5_ll;
    logic [SW-1:0]        r6_sq;

    assign n1_size = {i_hi[W-1], i_hi} - {i_lo[W-1], i_lo};

    assign n2_d2 = {r1_d, 1'b0};
    assign n2_sz = {r1_size[W], r1_size};
    assign n2_dx = {r1_d[W], r1_d};

    assign n3_d2  = {r2_d, 1'b0};
    assign n3_nsz = -{r2_size[W+1], r2_size};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_d    <= {i_a[W-1], i_a} - {i_b[W-1], i_b};
            r1_size <= n1_size;
            r1_c    <= i_periodic && !n1_size[W] && (n1_size != '0);

            r2_d    <= (r1_c && (n2_d2 > n2_sz)) ? n2_dx - n2_sz : n2_dx;
            r2_size <= n2_sz;
            r2_c    <= r1_c;

            r3_d    <= (r2_c && (n3_d2 < n3_nsz)) ? r2_d + r2_size : r2_d;

            r4_m    <= r3_d[W+1] ? -r3_d : r3_d;

            r5_hh   <= r4_m[MW-1:LW] * r4_m[MW-1:LW];
            r5_hl   <= r4_m[MW-1:LW] * r4_m[LW-1:0];
            r5_ll   <= r4_m[LW-1:0] * r4_m[LW-1:0];

            r6_sq   <= (SW'(r5_hh) << (2 * LW)) + (SW'(r5_hl) << (LW + 1)) + SW'(r5_ll);
        end
    end

    assign o_sq = r6_sq;

endmodule

/* rtl/core/pbwd_isqrt.sv */
// ----------------------------------------------------------------------------
// pbwd_isqrt
// Integer square root rounded down, one root bit per pipeline stage.
// ----------------------------------------------------------------------------
module pbwd_isqrt #(
    parameter int ROOT_WIDTH = pbwd_pkg::COORD_WIDTH_DEF + 2
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [2*ROOT_WIDTH+1:0]   i_sum,
    output logic [ROOT_WIDTH-1:0]     o_root
);
    localparam int RW = ROOT_WIDTH;
    localparam int SW = 2 * RW + 2;

    logic [SW-1:0] w_rem  [0:RW];
    logic [RW-1:0] w_root [0:RW];

    assign w_rem[0]  = i_sum;
    assign w_root[0] = '0;

    for (genvar k = 0; k < RW; k++) begin : g_bit
        localparam int B = RW - 1 - k;
        logic [SW-1:0] n_trial;
        logic          n_take;
        logic [SW-1:0] r_rem;
        logic [RW-1:0] r_root;

        // (root + 2^B)^2 - root^2
        assign n_trial = (SW'(w_root[k]) << (B + 1)) | (SW'(1) << (2 * B));
        assign n_take  = w_rem[k] >= n_trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= n_take ? w_rem[k] - n_trial : w_rem[k];
                r_root <= n_take ? (w_root[k] | (RW'(1) << B)) : w_root[k];
            end
        end

        assign w_rem[k+1]  = r_rem;
        assign w_root[k+1] = r_root;
    end

    assign o_root = w_root[RW];

endmodule

/* bench/pbwd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbwd_checker
// Watches the point and result channels, predicts box test, wrap and
// minimum-image distance for every accepted word, and compares in order.
// ----------------------------------------------------------------------------
module pbwd_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic signed [31:0] i_ax,
    input  logic signed [31:0] i_ay,
    input  logic signed [31:0] i_az,
    input  logic signed [31:0] i_bx,
    input  logic signed [31:0] i_by,
    input  logic signed [31:0] i_bz,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic               i_inside,
    input  logic signed [31:0] i_wx,
    input  logic signed [31:0] i_wy,
    input  logic signed [31:0] i_wz,
    input  logic [32:0]        i_dist,
    output int                 o_errors,
    output int                 o_pending
);

    typedef struct packed {
        logic        a_in_box;
        logic [31:0] wx;
        logic [31:0] wy;
        logic [31:0] wz;
        logic [32:0] distance;
    } t_box_result;

    logic               periodic_q;
    logic signed [31:0] lower_q [3];
    logic signed [31:0] upper_q [3];
    t_box_result        expected_q [$];

    assign o_pending = expected_q.size();

    function automatic logic [32:0] isqrt(input logic [127:0] s);
        logic [63:0]  r;
        logic [63:0]  c;
        r = 0;
        for (int b = 52; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (128'(c) * 128'(c) <= s)
                r = c;
        end
        if (r > 64'h1_FFFF_FFFF)
            r = 64'h1_FFFF_FFFF;
        return r[32:0];
    endfunction

    function automatic t_box_result predict_box(input logic signed [31:0] a [3],
                                                input logic signed [31:0] b [3]);
        t_box_result    res;
        logic signed [63:0] lo, hi, sz, av, d, rem, w;
        logic [127:0]   sum;
        logic [63:0]    mag;
        logic [31:0]    wv [3];
        res.a_in_box = 1'b1;
        sum = 0;
        for (int j = 0; j < 3; j++) begin
            av = a[j];
            lo = lower_q[j];
            hi = upper_q[j];
            sz = hi - lo;
            w = av;
            if (av < lo || av > hi) begin
                res.a_in_box = 1'b0;
                if (sz > 0) begin
                    rem = (av - lo) % sz;
                    if (rem < 0)
                        rem += sz;
                    w = lo + rem;
                end
            end
            wv[j] = w[31:0];
            d = av - 64'(b[j]);
            if (periodic_q && sz > 0) begin
                if (2 * d > sz)
                    d -= sz;
                if (2 * d < -sz)
                    d += sz;
            end
            mag = d < 0 ? -d : d;
            sum += 128'(mag) * 128'(mag);
        end
        res.wx = wv[0];
        res.wy = wv[1];
        res.wz = wv[2];
        res.distance = isqrt(sum);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_box_result got, exp_r;
        logic signed [31:0] pa [3];
        logic signed [31:0] pb [3];
        if (!i_rst_n) begin
            periodic_q <= 1'b0;
            lower_q <= '{0, 0, 0};
            upper_q <= '{0, 0, 0};
            expected_q.delete();
            o_errors <= 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                pa = '{i_ax, i_ay, i_az};
                pb = '{i_bx, i_by, i_bz};
                expected_q.insert(expected_q.size(), predict_box(pa, pb));
            end
            if (i_out_valid && i_out_ready) begin
                got = '{i_inside, i_wx, i_wy, i_wz, i_dist};
                if (expected_q.size() == 0) begin
                    $error("result word with nothing expected");
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got != exp_r)
                        o_errors <= o_errors + 1;
                    if (got.a_in_box != exp_r.a_in_box)
                        $error("a_inside exp %0d got %0d", exp_r.a_in_box, got.a_in_box);
                    if (got.wx != exp_r.wx)
                        $error("wrapped_x exp %0h got %0h", exp_r.wx, got.wx);
                    if (got.wy != exp_r.wy)
                        $error("wrapped_y exp %0h got %0h", exp_r.wy, got.wy);
                    if (got.wz != exp_r.wz)
                        $error("wrapped_z exp %0h got %0h", exp_r.wz, got.wz);
                    if (got.distance != exp_r.distance)
                        $error("distance exp %0h got %0h", exp_r.distance, got.distance);
                end
            end
            // config lands after any same-edge input, which used the old value
            if (i_cfg_valid && i_cfg_ready) begin
                case (pbwd_pkg::t_cfg_index'(i_cfg_index))
                    pbwd_pkg::CFG_PERIODIC: periodic_q <= i_cfg_data[0];
                    pbwd_pkg::CFG_LOWER_X:  lower_q[0] <= i_cfg_data;
                    pbwd_pkg::CFG_LOWER_Y:  lower_q[1] <= i_cfg_data;
                    pbwd_pkg::CFG_LOWER_Z:  lower_q[2] <= i_cfg_data;
                    pbwd_pkg::CFG_UPPER_X:  upper_q[0] <= i_cfg_data;
                    pbwd_pkg::CFG_UPPER_Y:  upper_q[1] <= i_cfg_data;
                    pbwd_pkg::CFG_UPPER_Z:  upper_q[2] <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end
endmodule

/* bench/periodic_box_wrap_and_distance_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_box_wrap_and_distance_tb
// Drives point pairs through several box settings with bursty input and a
// stalling receiver; the checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module periodic_box_wrap_and_distance_tb;

    localparam int LATENCY     = 41;
    localparam int IDLE_LIMIT  = 5000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [31:0] ax = 0, ay = 0, az = 0, bx = 0, by = 0, bz = 0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               out_in_box;
    logic signed [31:0] wx, wy, wz;
    logic [32:0]        out_distance;
    int                 errors;
    int                 pending;
    bit                 hold_off = 1'b0;
    int                 idle_cycles = 0;

    always #6 i_clk = ~i_clk;

    periodic_box_wrap_and_distance u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_point_a_x(ax), .i_point_a_y(ay), .i_point_a_z(az),
        .i_point_b_x(bx), .i_point_b_y(by), .i_point_b_z(bz),
        .o_valid(out_valid), .i_ready(out_ready), .o_a_inside(out_in_box),
        .o_wrapped_x(wx), .o_wrapped_y(wy), .o_wrapped_z(wz),
        .o_distance(out_distance)
    );

    pbwd_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_ax(ax), .i_ay(ay), .i_az(az), .i_bx(bx), .i_by(by), .i_bz(bz),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_inside(out_in_box),
        .i_wx(wx), .i_wy(wy), .i_wz(wz), .i_dist(out_distance),
        .o_errors(errors), .o_pending(pending)
    );

    // receiver: own stall pattern, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_off)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 1 && pending > 30);
    end

    // watchdog on cycles with no accepted word
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // valid stays up across back-to-back writes; drop it after the last
    task automatic write_reg(input pbwd_pkg::t_cfg_index idx, input logic [31:0] value,
                             input bit last_write);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ready);
        if (last_write)
            cfg_valid <= 1'b0;
    endtask

    task automatic set_box(input bit per, input logic [31:0] lo [3], input logic [31:0] hi [3]);
        write_reg(pbwd_pkg::CFG_PERIODIC, {31'd0, per}, 1'b0);
        write_reg(pbwd_pkg::CFG_LOWER_X, lo[0], 1'b0);
        write_reg(pbwd_pkg::CFG_LOWER_Y, lo[1], 1'b0);
        write_reg(pbwd_pkg::CFG_LOWER_Z, lo[2], 1'b0);
        write_reg(pbwd_pkg::CFG_UPPER_X, hi[0], 1'b0);
        write_reg(pbwd_pkg::CFG_UPPER_Y, hi[1], 1'b0);
        write_reg(pbwd_pkg::CFG_UPPER_Z, hi[2], 1'b1);
    endtask

    // send one pair; valid stays up across back-to-back words
    task automatic send_pair(input logic [31:0] p [6], input bit last_in_burst);
        in_valid <= 1'b1;
        ax <= p[0]; ay <= p[1]; az <= p[2];
        bx <= p[3]; by <= p[4]; bz <= p[5];
        do @(posedge i_clk); while (!in_ready);
        if (last_in_burst)
            in_valid <= 1'b0;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (pending != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    function automatic logic [31:0] coord_near(input logic signed [31:0] lo,
                                               input logic signed [31:0] hi);
        logic signed [63:0] span, v;
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            2: return $urandom_range(0, 1) ? lo : hi;
            default: begin
                span = 64'(hi) - 64'(lo) + 1;
                if (span < 1) span = 1;
                v = 64'(lo) + $signed(64'($urandom_range(0, 32'hFFFF_FFFF))) % (3 * span) - span;
                if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
                if (v < -64'sh8000_0000) v = -64'sh8000_0000;
                return v[31:0];
            end
        endcase
    endfunction

    task automatic random_phase(input int count, input logic [31:0] lo [3],
                                input logic [31:0] hi [3]);
        logic [31:0] p [6];
        int burst;
        int n;
        n = 0;
        while (n < count) begin
            burst = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8);
            for (int k = 0; k < burst && n < count; k++) begin
                for (int j = 0; j < 3; j++) begin
                    p[j]     = coord_near(lo[j], hi[j]);
                    p[3 + j] = coord_near(lo[j], hi[j]);
                end
                send_pair(p, (k == burst - 1) || (n == count - 1));
                n++;
            end
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    initial begin
        logic [31:0] lo [3];
        logic [31:0] hi [3];
        logic [31:0] p [6];
        logic [31:0] edge_vals [6];
        edge_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                      32'h0001_0000, 32'h5555_AAAA};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset box (size zero), then a periodic box, full range in x
        for (int k = 0; k < 6; k++) begin
            p = '{edge_vals[k], edge_vals[5 - k], edge_vals[(k + 2) % 6],
                  edge_vals[(k + 3) % 6], edge_vals[k], edge_vals[(k + 1) % 6]};
            send_pair(p, k == 5);
        end
        drain();
        lo = '{32'h8000_0000, 32'hFFFF_0000, 32'h0000_0000};
        hi = '{32'h7FFF_FFFF, 32'h0001_0000, 32'h000A_0000};
        set_box(1'b1, lo, hi);
        for (int k = 0; k < 12; k++) begin
            p = '{edge_vals[k % 6], edge_vals[(k + 1) % 6], edge_vals[(k + 4) % 6],
                  edge_vals[(k + 3) % 6], edge_vals[(k + 5) % 6], edge_vals[(k + 2) % 6]};
            send_pair(p, 1'b0);
        end
        // minimum-image boundary: difference exactly half the size in z
        p = '{32'h0, 32'h0001_0000, 32'h000A_0000, 32'h0, 32'hFFFF_0000, 32'h0005_0000};
        send_pair(p, 1'b1);
        drain();

        // long receiver hold-off while the sender keeps offering words
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            random_phase(150, lo, hi);
        join
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            for (int j = 0; j < 3; j++) begin
                case ((phase + j) % 4)
                    0: begin lo[j] = $urandom(); hi[j] = lo[j]; end
                    1: begin
                        lo[j] = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
                        hi[j] = lo[j] + $urandom_range(1, 32'h00FF_FFFF);
                    end
                    2: begin lo[j] = $urandom(); hi[j] = $urandom(); end
                    default: begin lo[j] = 32'h8000_0000; hi[j] = 32'h7FFF_FFFF; end
                endcase
            end
            set_box(phase[0], lo, hi);
            random_phase(190, lo, hi);
            drain();
        end

        if (errors == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
